### design/iir_order3_spike_reject_filter_assert.svh
// Assertion macros used by the spike-reject filter top level.
`ifndef IIR_ORDER3_SPIKE_REJECT_FILTER_ASSERT_SVH
`define IIR_ORDER3_SPIKE_REJECT_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iosr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IOSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iosr: next-cycle check failed");

`endif

### design/iosr_pkg.sv
// Constants, types and helper functions shared by the spike-reject filter modules.
package iosr_pkg;

    localparam int ORDER      = 3;
    localparam int NUM_AXES   = 2;
    localparam int AXIS_W     = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int SAMPLE_W   = 12;
    localparam int OUT_W      = 16;
    localparam int COEF_W     = 24;
    localparam int LIMIT_W    = 12;
    localparam int FRAC_BITS  = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = OUT_W + COEF_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int Q_W        = ACC_W - FRAC_BITS;
    localparam int NUM_STAGES = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_3   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LIMIT = 3'd7;

    // Reset values of the configuration registers (Q2.22 coefficients).
    localparam logic [COEF_W-1:0] FF_COEF_0_RST   = 24'sd75912;
    localparam logic [COEF_W-1:0] FF_COEF_1_RST   = 24'sd227737;
    localparam logic [COEF_W-1:0] FF_COEF_2_RST   = 24'sd227737;
    localparam logic [COEF_W-1:0] FF_COEF_3_RST   = 24'sd75912;
    localparam logic [COEF_W-1:0] FB_COEF_1_RST   = -24'sd7382151;
    localparam logic [COEF_W-1:0] FB_COEF_2_RST   = 24'sd4961414;
    localparam logic [COEF_W-1:0] FB_COEF_3_RST   = -24'sd1166268;
    localparam logic [LIMIT_W-1:0] SPIKE_LIMIT_RST = 12'd1000;

    // History reset values.
    localparam logic [SAMPLE_W-1:0] HIST_RST_AXIS0 = 12'd2400;
    localparam logic [SAMPLE_W-1:0] HIST_RST_OTHER = 12'd2000;

    typedef struct packed {
        logic [ORDER:0][COEF_W-1:0] ff;
        logic [ORDER:1][COEF_W-1:0] fb;
        logic [LIMIT_W-1:0]         spike_limit;
    } t_coefs;

    // Per-axis history; index 0 is the most recent entry.
    typedef struct packed {
        logic [ORDER-1:0][SAMPLE_W-1:0] x;
        logic [ORDER-1:0][OUT_W-1:0]    y;
    } t_hist;

    typedef struct packed {
        logic              re;
        logic [AXIS_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic              en;
        logic [AXIS_W-1:0] addr;
        t_hist             data;
    } t_mem_wr;

    // History contents of an axis that has never been written.
    function automatic t_hist hist_reset(input logic [AXIS_W-1:0] axis);
        t_hist               h;
        logic [SAMPLE_W-1:0] v;
        v = (axis == '0) ? HIST_RST_AXIS0 : HIST_RST_OTHER;
        for (int k = 0; k < ORDER; k++) begin
            h.x[k] = v;
            h.y[k] = OUT_W'(v);
        end
        return h;
    endfunction

endpackage

### design/iosr_ram.sv
// Generic single-write, single-read memory with a registered read port.
module iosr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/iosr_cfg_regs.sv
// Configuration register file holding the filter coefficients and the spike limit.
module iosr_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [iosr_pkg::CFG_IDX_W-1:0]      i_index,
    input  logic [iosr_pkg::CFG_DATA_W-1:0]     i_data,
    output iosr_pkg::t_coefs                    o_coefs
);

    iosr_pkg::t_coefs r_coefs;
    iosr_pkg::t_coefs n_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_wr_en) begin
            case (i_index)
                iosr_pkg::REG_FF_COEF_0:   n_coefs.ff[0] = i_data[iosr_pkg::COEF_W-1:0];
                iosr_pkg::REG_FF_COEF_1:   n_coefs.ff[1] = i_data[iosr_pkg::COEF_W-1:0];
                iosr_pkg::REG_FF_COEF_2:   n_coefs.ff[2] = i_data[iosr_pkg::COEF_W-1:0];
                iosr_pkg::REG_FF_COEF_3:   n_coefs.ff[3] = i_data[iosr_pkg::COEF_W-1:0];
                iosr_pkg::REG_FB_COEF_1:   n_coefs.fb[1] = i_data[iosr_pkg::COEF_W-1:0];
                iosr_pkg::REG_FB_COEF_2:   n_coefs.fb[2] = i_data[iosr_pkg::COEF_W-1:0];
                iosr_pkg::REG_FB_COEF_3:   n_coefs.fb[3] = i_data[iosr_pkg::COEF_W-1:0];
                iosr_pkg::REG_SPIKE_LIMIT: begin
                    n_coefs.spike_limit = i_data[iosr_pkg::LIMIT_W-1:0];
                end
                default: n_coefs = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.ff[0]       <= iosr_pkg::FF_COEF_0_RST;
            r_coefs.ff[1]       <= iosr_pkg::FF_COEF_1_RST;
            r_coefs.ff[2]       <= iosr_pkg::FF_COEF_2_RST;
            r_coefs.ff[3]       <= iosr_pkg::FF_COEF_3_RST;
            r_coefs.fb[1]       <= iosr_pkg::FB_COEF_1_RST;
            r_coefs.fb[2]       <= iosr_pkg::FB_COEF_2_RST;
            r_coefs.fb[3]       <= iosr_pkg::FB_COEF_3_RST;
            r_coefs.spike_limit <= iosr_pkg::SPIKE_LIMIT_RST;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

### design/iosr_pipe.sv
// Filter pipeline: history read-back, spike rejection, tap products, adder tree and saturation.
module iosr_pipe (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [iosr_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic [iosr_pkg::AXIS_W-1:0]          i_axis,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [iosr_pkg::OUT_W-1:0]    o_filtered,
    output logic [iosr_pkg::AXIS_W-1:0]          o_axis_out,
    input  iosr_pkg::t_coefs                     i_coefs,
    output iosr_pkg::t_mem_rd                    o_mem_rd,
    input  iosr_pkg::t_hist                      i_mem_rdata,
    output iosr_pkg::t_mem_wr                    o_mem_wr
);

    localparam int NS     = iosr_pkg::NUM_STAGES;
    localparam int ORDER  = iosr_pkg::ORDER;
    localparam int PW     = iosr_pkg::PROD_W;
    localparam int AW     = iosr_pkg::ACC_W;
    localparam int QW     = iosr_pkg::Q_W;
    localparam int FB     = iosr_pkg::FRAC_BITS;
    localparam int SW     = iosr_pkg::SAMPLE_W;
    localparam int OW     = iosr_pkg::OUT_W;
    localparam logic signed [QW-1:0] Q_MAX = QW'((1 << (OW - 1)) - 1);
    localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);

    // Stage control.
    logic [NS:1]                         r_vld;
    logic [NS:1][iosr_pkg::AXIS_W-1:0]   r_ax;
    logic [NS:1]                         w_load;
    logic                                w_out_free;
    logic                                w_hazard;
    logic                                w_accept;
    logic [iosr_pkg::NUM_AXES-1:0]       r_written;

    // Stage 1: raw sample, history arrives from memory.
    logic [SW-1:0]                       r_sample1;
    iosr_pkg::t_hist                     w_hist1;
    logic signed [SW+1:0]                w_rise;
    logic                                w_spike;
    logic [SW-1:0]                       w_x_new;

    // Stage 2: shifted taps.
    logic [ORDER:0][SW-1:0]              r_xs2;
    logic [ORDER:1][OW-1:0]              r_ys2;
    iosr_pkg::t_hist                     w_carry2;

    // Stage 3: products.
    logic signed [PW-1:0]                w_pff [0:ORDER];
    logic signed [PW-1:0]                w_pfb [1:ORDER];
    logic signed [PW-1:0]                r_pff3 [0:ORDER];
    logic signed [PW-1:0]                r_pfb3 [1:ORDER];

    // Stages 4 to 6: adder tree.
    logic signed [AW-1:0]                w_s4 [0:3];
    logic signed [AW-1:0]                r_s4 [0:3];
    logic signed [AW-1:0]                w_u5;
    logic signed [AW-1:0]                w_v5;
    logic signed [AW-1:0]                r_u5;
    logic signed [AW-1:0]                r_v5;
    logic signed [AW-1:0]                w_acc6;
    logic signed [AW-1:0]                r_acc6;

    // History that travels alongside the arithmetic for write-back.
    iosr_pkg::t_hist                     r_carry [3:NS];

    // Output stage.
    logic signed [QW-1:0]                w_q_floor;
    logic                                w_q_adj;
    logic signed [QW-1:0]                w_q;
    logic signed [OW-1:0]                w_y;
    logic                                w_wr_en;
    logic                                r_out_valid;
    logic signed [OW-1:0]                r_out_y;
    logic [iosr_pkg::AXIS_W-1:0]         r_out_ax;

    // Ready chain and same-axis interlock.
    always_comb begin
        w_out_free = !r_out_valid || !i_stall;
        w_load[NS] = !r_vld[NS] || w_out_free;
        for (int k = NS - 1; k >= 1; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
        w_hazard = 1'b0;
        for (int k = 1; k <= NS; k++) begin
            w_hazard = w_hazard || (r_vld[k] && (r_ax[k] == i_axis));
        end
    end

    assign o_stall  = !w_load[1] || w_hazard;
    assign w_accept = i_valid && !o_stall;

    assign o_mem_rd.re   = w_accept;
    assign o_mem_rd.addr = i_axis;

    // Spike rejection against the previous stored input.
    always_comb begin
        w_hist1 = r_written[r_ax[1]] ? i_mem_rdata : iosr_pkg::hist_reset(r_ax[1]);
        w_rise  = $signed({2'b00, r_sample1}) - $signed({2'b00, w_hist1.x[0]});
        w_spike = w_rise > $signed({2'b00, i_coefs.spike_limit});
        w_x_new = w_spike ? w_hist1.x[0] : r_sample1;
    end

    always_comb begin
        w_carry2 = '0;
        for (int k = 0; k < ORDER; k++) begin
            w_carry2.x[k] = r_xs2[k];
        end
        for (int k = 1; k < ORDER; k++) begin
            w_carry2.y[k] = r_ys2[k];
        end
        for (int k = 0; k <= ORDER; k++) begin
            w_pff[k] = $signed({1'b0, r_xs2[k]}) * $signed(i_coefs.ff[k]);
        end
        for (int k = 1; k <= ORDER; k++) begin
            w_pfb[k] = $signed(r_ys2[k]) * $signed(i_coefs.fb[k]);
        end
    end

    always_comb begin
        w_s4[0] = AW'(r_pff3[0]) + AW'(r_pff3[1]);
        w_s4[1] = AW'(r_pff3[2]) + AW'(r_pff3[3]);
        w_s4[2] = AW'(r_pfb3[1]) + AW'(r_pfb3[2]);
        w_s4[3] = AW'(r_pfb3[3]);
        w_u5    = r_s4[0] + r_s4[1];
        w_v5    = r_s4[2] + r_s4[3];
        w_acc6  = r_u5 - r_v5;
    end

    // Divide by 2^FRAC_BITS rounding toward zero, then clamp to the output range.
    always_comb begin
        w_q_floor = r_acc6[AW-1:FB];
        w_q_adj   = r_acc6[AW-1] && (|r_acc6[FB-1:0]);
        w_q       = w_q_floor + $signed({{(QW-1){1'b0}}, w_q_adj});
        if (w_q > Q_MAX) begin
            w_y = Q_MAX[OW-1:0];
        end else if (w_q < Q_MIN) begin
            w_y = Q_MIN[OW-1:0];
        end else begin
            w_y = w_q[OW-1:0];
        end
        w_wr_en = r_vld[NS] && w_out_free;
    end

    always_comb begin
        o_mem_wr.en        = w_wr_en;
        o_mem_wr.addr      = r_ax[NS];
        o_mem_wr.data      = r_carry[NS];
        o_mem_wr.data.y[0] = w_y;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load[1]) begin
                r_vld[1] <= w_accept;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_wr_en) begin
                r_written[r_ax[NS]] <= 1'b1;
            end
            if (w_out_free) begin
                r_out_valid <= r_vld[NS];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_load[1]) begin
            r_ax[1]   <= i_axis;
            r_sample1 <= i_sample;
        end
        for (int k = 2; k <= NS; k++) begin
            if (w_load[k]) begin
                r_ax[k] <= r_ax[k-1];
            end
        end
        if (w_load[2]) begin
            r_xs2[0] <= w_x_new;
            for (int k = 1; k <= ORDER; k++) begin
                r_xs2[k] <= w_hist1.x[k-1];
                r_ys2[k] <= w_hist1.y[k-1];
            end
        end
        if (w_load[3]) begin
            r_carry[3] <= w_carry2;
            for (int k = 0; k <= ORDER; k++) begin
                r_pff3[k] <= w_pff[k];
            end
            for (int k = 1; k <= ORDER; k++) begin
                r_pfb3[k] <= w_pfb[k];
            end
        end
        if (w_load[4]) begin
            r_carry[4] <= r_carry[3];
            for (int k = 0; k < 4; k++) begin
                r_s4[k] <= w_s4[k];
            end
        end
        if (w_load[5]) begin
            r_carry[5] <= r_carry[4];
            r_u5       <= w_u5;
            r_v5       <= w_v5;
        end
        if (w_load[6]) begin
            r_carry[6] <= r_carry[5];
            r_acc6     <= w_acc6;
        end
        if (w_wr_en) begin
            r_out_y  <= w_y;
            r_out_ax <= r_ax[NS];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_y;
    assign o_axis_out = r_out_ax;

endmodule

### design/iir_order3_spike_reject_filter.sv
// Top level of the third-order IIR filter with upward spike rejection, one history per axis.
//
// Usage: a sample and its axis number enter on the input channel (i_valid, o_stall) and one
// filtered value with its axis leaves on the output channel (o_valid, i_stall); a transaction
// completes on a rising edge where valid is high and stall is low. Coefficients and the spike
// limit are written through the configuration channel (i_cfg_valid, o_cfg_ready), which is
// always ready; they should only be changed while no transaction is in flight.
// An accepted transaction passes through the pipeline stages and then the output register.
// Each axis keeps its history in one word of a small two-entry memory that is read at
// acceptance and written back when the result leaves the last stage. A transaction for an
// axis that already has one in flight is held off by o_stall until that write-back, so one
// axis cannot start a new transaction before its last one is written back; transactions for
// alternating axes overlap. Different axes never wait on each other otherwise.
// Reset (synchronous, i_rst_n low) restores the default coefficients and marks both history
// words as unwritten, so they read as 2400 (X axis) and 2000 (Y axis) until first updated.
// When the receiver stalls, the finished result holds in the output register and the stages
// behind it fill up; new transactions are still accepted until every axis has one waiting in
// the stages behind the output register.
`include "iir_order3_spike_reject_filter_assert.svh"

module iir_order3_spike_reject_filter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [iosr_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic [iosr_pkg::AXIS_W-1:0]          i_axis,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [iosr_pkg::OUT_W-1:0]    o_filtered,
    output logic [iosr_pkg::AXIS_W-1:0]          o_axis_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [iosr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [iosr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    iosr_pkg::t_coefs  w_coefs;
    iosr_pkg::t_mem_rd w_mem_rd;
    iosr_pkg::t_mem_wr w_mem_wr;
    iosr_pkg::t_hist   w_mem_rdata;

    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;

    iosr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_coefs (w_coefs)
    );

    // One history word per axis: the last three inputs and the last three outputs.
    iosr_ram #(
        .WIDTH ($bits(iosr_pkg::t_hist)),
        .DEPTH (iosr_pkg::NUM_AXES)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_wr.en),
        .i_waddr (w_mem_wr.addr),
        .i_wdata (w_mem_wr.data),
        .i_re    (w_mem_rd.re),
        .i_raddr (w_mem_rd.addr),
        .o_rdata (w_mem_rdata)
    );

    iosr_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_axis      (i_axis),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_filtered  (o_filtered),
        .o_axis_out  (o_axis_out),
        .i_coefs     (w_coefs),
        .o_mem_rd    (w_mem_rd),
        .i_mem_rdata (w_mem_rdata),
        .o_mem_wr    (w_mem_wr)
    );

    // The interlock must never let a history read and its write-back meet on one axis.
    `IOSR_ASSERT_SAME(a_no_rw_clash, i_clk, i_rst_n, w_mem_rd.re && w_mem_wr.en, w_mem_rd.addr != w_mem_wr.addr)

    // Every write-back is presented as a result on the following cycle, for the same axis.
    `IOSR_ASSERT_NEXT(a_wb_gives_result, i_clk, i_rst_n, w_mem_wr.en, o_valid && (o_axis_out == $past(w_mem_wr.addr)))

    // A result only appears after its history has been written back.
    `IOSR_ASSERT_SAME(a_result_after_wb, i_clk, i_rst_n, $rose(o_valid), $past(w_mem_wr.en))

endmodule
